FILE: rtl/skvt_pkg.sv
// Package for the sorted key/value table: sizes, opcodes, status codes,
// cell control types. No dependencies.
`default_nettype none

package skvt_pkg;

    localparam int CAPACITY = 16;
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    localparam int FUNC_W  = 3;
    localparam int KEY_W   = 32;
    localparam int VAL_W   = 8;
    localparam int ECNT_W  = 5;
    localparam int STAT_W  = 2;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_INSERT = 3'd0,
        FUNC_REMOVE = 3'd1,
        FUNC_LOOKUP = 3'd2,
        FUNC_CLEAR  = 3'd3,
        FUNC_DUMP   = 3'd4
    } func_t;

    localparam logic [STAT_W-1:0] STAT_OK     = 2'd0;
    localparam logic [STAT_W-1:0] STAT_FULL   = 2'd1;
    localparam logic [STAT_W-1:0] STAT_ABSENT = 2'd2;

    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_LOAD,
        CELL_FROM_PREV,
        CELL_FROM_NEXT,
        CELL_SET_VALUE
    } cell_op_t;

    typedef struct packed {
        cell_op_t op;
        logic     occ;
    } cell_ctrl_t;

endpackage

`default_nettype wire

FILE: rtl/skvt_req_if.sv
// Request and response channel interfaces for the sorted key/value table.
// Depends on skvt_pkg.
`default_nettype none

interface skvt_req_if
    import skvt_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [FUNC_W-1:0]  func;
    logic [KEY_W-1:0]   key;
    logic [VAL_W-1:0]   value;

    modport source (output valid, output func, output key, output value, input ready);
    modport sink   (input valid, input func, input key, input value, output ready);
endinterface

interface skvt_rsp_if
    import skvt_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [VAL_W-1:0]   value_out;
    logic               found;
    logic [ECNT_W-1:0]  entry_count;
    logic [STAT_W-1:0]  status;
    logic               last;

    modport source (output valid, output value_out, output found, output entry_count,
                    output status, output last, input ready);
    modport sink   (input valid, input value_out, input found, input entry_count,
                    input status, input last, output ready);
endinterface

`default_nettype wire

FILE: rtl/skvt_cell.sv
// One cell of the sorted chain: holds a key/value entry, compares it with
// the probe key and loads from its neighbors. Depends on skvt_pkg.
`default_nettype none

module skvt_cell
    import skvt_pkg::*;
(
    input  wire logic              clk,
    input  wire cell_ctrl_t        ctrl,
    input  wire logic [KEY_W-1:0]  probe_key,
    input  wire logic [VAL_W-1:0]  new_value,
    input  wire logic [KEY_W-1:0]  prev_key,
    input  wire logic [VAL_W-1:0]  prev_value,
    input  wire logic [KEY_W-1:0]  next_key,
    input  wire logic [VAL_W-1:0]  next_value,
    output logic [KEY_W-1:0]       key,
    output logic [VAL_W-1:0]       value,
    output logic                   lt,
    output logic                   eq
);

    logic [KEY_W-1:0] key_reg, key_next;
    logic [VAL_W-1:0] value_reg, value_next;

    always_comb
    begin
        key_next   = key_reg;
        value_next = value_reg;
        case (ctrl.op)
            CELL_LOAD:
            begin
                key_next   = probe_key;
                value_next = new_value;
            end
            CELL_FROM_PREV:
            begin
                key_next   = prev_key;
                value_next = prev_value;
            end
            CELL_FROM_NEXT:
            begin
                key_next   = next_key;
                value_next = next_value;
            end
            CELL_SET_VALUE: value_next = new_value;
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        key_reg   <= key_next;
        value_reg <= value_next;
    end

    assign key   = key_reg;
    assign value = value_reg;
    assign lt    = ctrl.occ && (key_reg < probe_key);
    assign eq    = ctrl.occ && (key_reg == probe_key);

endmodule

`default_nettype wire

FILE: rtl/sorted_key_value_table.sv
// Sorted key/value table built as a chain of compare-and-shift cells; uses
// skvt_pkg, skvt_req_if/skvt_rsp_if and skvt_cell.
// Single-result requests: result computed in S_EXEC, registered once the
// output is free; no new request is taken until then. A dump holds off
// requests, rotating the chain through cell 0 and emitting one result
// per cycle unless stalled. Reset (async, active low) empties the table.
`default_nettype none

module sorted_key_value_table
    import skvt_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    skvt_req_if.sink   req,
    skvt_rsp_if.source rsp
);

    typedef enum logic [1:0] {S_IDLE, S_EXEC, S_DUMP} state_t;

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [CNT_W-1:0]   idx_reg, idx_next;
    logic [FUNC_W-1:0]  func_reg;
    logic [KEY_W-1:0]   key_reg;
    logic [VAL_W-1:0]   value_reg;

    logic               out_valid_reg, out_valid_next;
    logic [VAL_W-1:0]   out_value_reg, out_value_next;
    logic               out_found_reg, out_found_next;
    logic [ECNT_W-1:0]  out_count_reg, out_count_next;
    logic [STAT_W-1:0]  out_status_reg, out_status_next;
    logic               out_last_reg, out_last_next;

    cell_ctrl_t          ctrl   [CAPACITY];
    logic [KEY_W-1:0]    c_key  [CAPACITY];
    logic [VAL_W-1:0]    c_val  [CAPACITY];
    logic [CAPACITY-1:0] lt_vec, eq_vec;

    logic               accept, out_free, hit, full;
    logic [VAL_W-1:0]   hit_value;

    assign accept   = req.valid && req.ready;
    assign req.ready = (state_reg == S_IDLE);
    assign out_free = !out_valid_reg || rsp.ready;

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++)
        begin : g_cell
            localparam int PI = (g == 0) ? CAPACITY - 1 : g - 1;
            localparam int NI = (g == CAPACITY - 1) ? 0 : g + 1;
            skvt_cell u_cell (
                .clk        (clk),
                .ctrl       (ctrl[g]),
                .probe_key  (key_reg),
                .new_value  (value_reg),
                .prev_key   (c_key[PI]),
                .prev_value (c_val[PI]),
                .next_key   (c_key[NI]),
                .next_value (c_val[NI]),
                .key        (c_key[g]),
                .value      (c_val[g]),
                .lt         (lt_vec[g]),
                .eq         (eq_vec[g])
            );
        end
    endgenerate

    assign hit  = |eq_vec;
    assign full = (count_reg == CNT_W'(CAPACITY));

    always_comb
    begin
        hit_value = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            if (eq_vec[i])
            begin
                hit_value = hit_value | c_val[i];
            end
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        idx_next        = idx_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_value_next  = out_value_reg;
        out_found_next  = out_found_reg;
        out_count_next  = out_count_reg;
        out_status_next = out_status_reg;
        out_last_next   = out_last_reg;
        for (int i = 0; i < CAPACITY; i++)
        begin
            ctrl[i].occ = (CNT_W'(i) < count_reg);
            ctrl[i].op  = CELL_HOLD;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (out_free)
                begin
                    state_next      = S_IDLE;
                    out_valid_next  = 1'b1;
                    out_value_next  = '0;
                    out_found_next  = 1'b0;
                    out_status_next = STAT_OK;
                    out_last_next   = 1'b1;
                    case (func_reg)
                        FUNC_INSERT:
                        begin
                            out_found_next = hit;
                            if (hit)
                            begin
                                for (int i = 0; i < CAPACITY; i++)
                                begin
                                    if (eq_vec[i])
                                    begin
                                        ctrl[i].op = CELL_SET_VALUE;
                                    end
                                end
                            end
                            else if (full)
                            begin
                                out_status_next = STAT_FULL;
                            end
                            else
                            begin
                                count_next = count_reg + 1'b1;
                                for (int i = 0; i < CAPACITY; i++)
                                begin
                                    if (lt_vec[i])
                                    begin
                                        ctrl[i].op = CELL_HOLD;
                                    end
                                    else if (i == 0 || lt_vec[(i == 0) ? 0 : i - 1])
                                    begin
                                        ctrl[i].op = CELL_LOAD;
                                    end
                                    else
                                    begin
                                        ctrl[i].op = CELL_FROM_PREV;
                                    end
                                end
                            end
                        end
                        FUNC_REMOVE:
                        begin
                            out_found_next = hit;
                            if (hit)
                            begin
                                count_next = count_reg - 1'b1;
                                for (int i = 0; i < CAPACITY; i++)
                                begin
                                    if (!lt_vec[i])
                                    begin
                                        ctrl[i].op = CELL_FROM_NEXT;
                                    end
                                end
                            end
                            else
                            begin
                                out_status_next = STAT_ABSENT;
                            end
                        end
                        FUNC_LOOKUP:
                        begin
                            out_found_next = hit;
                            out_value_next = hit_value;
                            if (!hit)
                            begin
                                out_status_next = STAT_ABSENT;
                            end
                        end
                        FUNC_CLEAR: count_next = '0;
                        FUNC_DUMP:
                        begin
                            if (count_reg == '0)
                            begin
                                out_status_next = STAT_ABSENT;
                            end
                            else
                            begin
                                out_valid_next = out_valid_reg && !rsp.ready;
                                state_next     = S_DUMP;
                                idx_next       = '0;
                            end
                        end
                        default: ;
                    endcase
                    if (state_next == S_IDLE)
                    begin
                        out_count_next = ECNT_W'(count_next);
                    end
                end
            end
            S_DUMP:
            begin
                if (idx_reg < count_reg)
                begin
                    if (out_free)
                    begin
                        out_valid_next  = 1'b1;
                        out_value_next  = c_val[0];
                        out_found_next  = 1'b0;
                        out_count_next  = ECNT_W'(count_reg);
                        out_status_next = STAT_OK;
                        out_last_next   = (idx_reg == count_reg - 1'b1);
                        idx_next        = idx_reg + 1'b1;
                        for (int i = 0; i < CAPACITY; i++)
                        begin
                            ctrl[i].op = CELL_FROM_NEXT;
                        end
                    end
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                    for (int i = 0; i < CAPACITY; i++)
                    begin
                        ctrl[i].op = CELL_FROM_NEXT;
                    end
                end
                if (idx_next == CNT_W'(CAPACITY))
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            func_reg  <= req.func;
            key_reg   <= req.key;
            value_reg <= req.value;
        end
        out_value_reg  <= out_value_next;
        out_found_reg  <= out_found_next;
        out_count_reg  <= out_count_next;
        out_status_reg <= out_status_next;
        out_last_reg   <= out_last_next;
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.value_out   = out_value_reg;
    assign rsp.found       = out_found_reg;
    assign rsp.entry_count = out_count_reg;
    assign rsp.status      = out_status_reg;
    assign rsp.last        = out_last_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("entry count exceeds capacity");

    a_unique_keys: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_EXEC |-> $onehot0(eq_vec))
        else $error("duplicate key in table");

    a_sorted_prefix: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_EXEC |-> (lt_vec & (lt_vec + CAPACITY'(1))) == '0)
        else $error("chain not in key order");

    a_dump_rsp_order: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DUMP && idx_reg < count_reg && out_free |=>
        rsp.valid && rsp.last == (idx_reg == count_reg))
        else $error("dump last flag out of place");

endmodule

`default_nettype wire
